@@ design/inverse_cdf_time_lookup_defines.svh @@
// Assertion macros shared by the inverse-CDF time lookup design.
`ifndef INVERSE_CDF_TIME_LOOKUP_DEFINES_SVH
`define INVERSE_CDF_TIME_LOOKUP_DEFINES_SVH

// Same-cycle implication, clocked on i_clk and disabled during reset.
`define ICDF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("icdf: same-cycle implication violated");

// Next-cycle implication, clocked on i_clk and disabled during reset.
`define ICDF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("icdf: next-cycle implication violated");

`endif

@@ design/icdf_pkg.sv @@
// Types and constants for the inverse-CDF time lookup.
`timescale 1ns / 1ps
`default_nettype none
package icdf_pkg;

    localparam int RATE_W   = 25;
    localparam int AGE_W    = 32;
    localparam int METAL_W  = 24;
    localparam int FRAC_BITS = 6;
    localparam int FIX_W    = AGE_W + FRAC_BITS;   // ages with fraction bits
    localparam int HALF_W   = FIX_W / 2;           // multiplier split point
    localparam int NUM_W    = RATE_W;              // interpolation weights
    localparam int PROD_W   = 64;

    typedef enum logic [1:0] {
        CMD_WR_RATE  = 2'd0,
        CMD_WR_AGE   = 2'd1,
        CMD_WR_METAL = 2'd2,
        CMD_QUERY    = 2'd3
    } t_cmd;

    // Register select bit of paddr (word 0 is tables_in_use).
    localparam logic REG_TABLES_IN_USE = 1'b0;
    localparam logic [3:0] TABLES_RESET = 4'd8;

    typedef struct packed {
        logic rate_we;
        logic age_we;
        logic grid_we;
    } t_store_wr;

    typedef struct packed {
        logic [FIX_W-1:0] a;
        logic [FIX_W-1:0] b;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] den;
    } t_lerp_req;

endpackage
`default_nettype wire

@@ design/icdf_store.sv @@
// Table memory (rate and age per entry) and metallicity grid memory.
`timescale 1ns / 1ps
`default_nettype none
module icdf_store #(
    parameter int MAX_TABLES    = 8,
    parameter int TABLE_ENTRIES = 100
) (
    input  wire                     i_clk,
    input  wire icdf_pkg::t_store_wr i_wr,
    input  wire  [$clog2(MAX_TABLES*TABLE_ENTRIES)-1:0] i_waddr,
    input  wire  [((MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1)-1:0] i_gwaddr,
    input  wire  [31:0]             i_wdata,
    input  wire  [$clog2(MAX_TABLES*TABLE_ENTRIES)-1:0] i_raddr,
    input  wire  [((MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1)-1:0] i_graddr,
    output logic [icdf_pkg::RATE_W-1:0]  o_rate,
    output logic [icdf_pkg::AGE_W-1:0]   o_age,
    output logic [icdf_pkg::METAL_W-1:0] o_grid
);
    import icdf_pkg::*;

    localparam int DEPTH = MAX_TABLES * TABLE_ENTRIES;
    localparam int WORD_W = AGE_W + RATE_W;

    logic [WORD_W-1:0]  r_tbl_mem [DEPTH];
    logic [METAL_W-1:0] r_grid_mem [MAX_TABLES];
    logic [WORD_W-1:0]  r_tbl_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.rate_we) begin
            r_tbl_mem[i_waddr][RATE_W-1:0] <= i_wdata[RATE_W-1:0];
        end
        if (i_wr.age_we) begin
            r_tbl_mem[i_waddr][WORD_W-1:RATE_W] <= i_wdata;
        end
        r_tbl_rd <= r_tbl_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.grid_we) begin
            r_grid_mem[i_gwaddr] <= i_wdata[METAL_W-1:0];
        end
        o_grid <= r_grid_mem[i_graddr];
    end

    assign o_rate = r_tbl_rd[RATE_W-1:0];
    assign o_age  = r_tbl_rd[WORD_W-1:RATE_W];

endmodule
`default_nettype wire

@@ design/icdf_lerp.sv @@
// Shared interpolation unit: a +/- round(|b-a|*num/den) (minus when b < a), split multiply and radix-2 divide.
`timescale 1ns / 1ps
`default_nettype none
module icdf_lerp (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire icdf_pkg::t_lerp_req     i_req,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [icdf_pkg::FIX_W-1:0]   o_result
);
    import icdf_pkg::*;

    localparam int CNT_W = $clog2(FIX_W);

    typedef enum logic [2:0] {
        L_IDLE,
        L_MUL_LO,
        L_MUL_HI,
        L_DIV,
        L_ADJ
    } t_lstate;

    t_lstate            r_state;
    logic               r_done;
    logic [FIX_W-1:0]   r_a;
    logic [FIX_W-1:0]   r_diff;
    logic               r_neg;
    logic [NUM_W-1:0]   r_num;
    logic [NUM_W-1:0]   r_den;
    logic [PROD_W-1:0]  r_prod;
    logic [NUM_W-1:0]   r_rem;
    logic [FIX_W-1:0]   r_q;
    logic [CNT_W-1:0]   r_cnt;
    logic [FIX_W-1:0]   r_result;

    logic [PROD_W-1:0]  n_prod;
    logic [NUM_W:0]     n_rem2;
    logic               n_qbit;

    always_comb begin
        n_prod = r_prod + (PROD_W'(r_diff[FIX_W-1:HALF_W] * r_num) << HALF_W);
        n_rem2 = {r_rem, r_q[FIX_W-1]};
        n_qbit = (n_rem2 >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_a   <= i_req.a;
                        r_neg <= (i_req.b < i_req.a);
                        r_diff <= (i_req.b < i_req.a) ? (i_req.a - i_req.b)
                                                      : (i_req.b - i_req.a);
                        r_num <= i_req.num;
                        r_den <= i_req.den;
                        r_state <= L_MUL_LO;
                    end
                end
                L_MUL_LO: begin
                    // Rounding term is folded in with the low partial product.
                    r_prod <= PROD_W'(r_diff[HALF_W-1:0] * r_num)
                            + PROD_W'(r_den >> 1);
                    r_state <= L_MUL_HI;
                end
                L_MUL_HI: begin
                    // The quotient fits FIX_W bits, so the top part is already below den.
                    r_rem <= n_prod[FIX_W +: NUM_W];
                    r_q   <= n_prod[FIX_W-1:0];
                    r_cnt <= '0;
                    r_state <= L_DIV;
                end
                L_DIV: begin
                    r_rem <= n_qbit ? NUM_W'(n_rem2 - {1'b0, r_den}) : n_rem2[NUM_W-1:0];
                    r_q   <= {r_q[FIX_W-2:0], n_qbit};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(FIX_W - 1)) begin
                        r_state <= L_ADJ;
                    end
                end
                L_ADJ: begin
                    r_result <= r_neg ? (r_a - r_q) : (r_a + r_q);
                    r_done   <= 1'b1;
                    r_state  <= L_IDLE;
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    assign o_busy   = (r_state != L_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
`default_nettype wire

@@ design/inverse_cdf_time_lookup.sv @@
// Top level of the inverse-CDF time lookup: command sequencer, config register, result register.
//
// Input channel (i_in_valid / o_in_stall) carries one command word: a rate,
// age or metallicity write, or a query. Writes go to memory in the cycle
// they are accepted and give no result. A query gives one result word on
// the output channel (o_out_valid / i_out_stall).
// A query reads the metallicity grid (two reads, then one read per grid
// point scanned), then for each table used makes two end reads and one
// read per binary-search probe, and interpolates in the shared unit; a
// draw off a table ends early.
// One item is in work at a time; o_in_stall is high while a query runs.
// The result sits in an output register; while the receiver stalls it,
// the next item is accepted, and a second result waits until it drains.
// Reset (synchronous, active low) empties the output register and sets
// tables_in_use to 8. Table and grid memories are not cleared.
// tables_in_use is written over the APB port at byte address 0.
`timescale 1ns / 1ps
`default_nettype none
module inverse_cdf_time_lookup #(
    parameter int TABLE_ENTRIES = 100,
    parameter int MAX_TABLES    = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [1:0]  i_command,
    input  wire  [2:0]  i_table_index,
    input  wire  [6:0]  i_entry_index,
    input  wire  [31:0] i_write_value,
    input  wire  [24:0] i_query_rate,
    input  wire  [23:0] i_query_metal,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [31:0] o_time_years,
    output logic        o_out_of_range,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import icdf_pkg::*;

`include "inverse_cdf_time_lookup_defines.svh"

    localparam int AW = $clog2(MAX_TABLES * TABLE_ENTRIES);
    localparam int TW = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
    localparam int EW = $clog2(TABLE_ENTRIES);
    localparam logic [5:0] MAXT = 6'(MAX_TABLES);

    typedef enum logic [3:0] {
        S_IDLE,
        S_G0,
        S_G0_CHK,
        S_GN_CHK,
        S_SCAN,
        S_SCAN_CHK,
        S_T_LO,
        S_T_HI,
        S_T_CHK,
        S_PROBE,
        S_STEP,
        S_T_LERP,
        S_T_WAIT,
        S_T_DONE,
        S_M_WAIT,
        S_FINISH
    } t_state;

    t_state              r_state;
    logic [3:0]          r_tin;
    logic                r_out_valid;
    logic [31:0]         r_time;
    logic                r_oor;
    logic [RATE_W-1:0]   r_rate;
    logic [METAL_W-1:0]  r_metal;
    logic                r_two;
    logic                r_second;
    logic                r_fail;
    logic [TW-1:0]       r_tsel;
    logic [TW-1:0]       r_i;
    logic [EW-1:0]       r_lo;
    logic [EW-1:0]       r_hi;
    logic [EW-1:0]       r_mid;
    logic [RATE_W-1:0]   r_rlo;
    logic [RATE_W-1:0]   r_rhi;
    logic [AGE_W-1:0]    r_alo;
    logic [AGE_W-1:0]    r_ahi;
    logic [METAL_W-1:0]  r_glo;
    logic [METAL_W-1:0]  r_ghi;
    logic [FIX_W-1:0]    r_tlo;
    logic [FIX_W-1:0]    r_age;

    logic                in_acc;
    logic                cfg_wr;
    logic                wr_ok;
    t_store_wr           st_wr;
    logic [AW-1:0]       st_waddr;
    logic [AW-1:0]       st_raddr;
    logic [AW-1:0]       tbl_base;
    logic [TW-1:0]       st_graddr;
    logic [RATE_W-1:0]   rd_rate;
    logic [AGE_W-1:0]    rd_age;
    logic [METAL_W-1:0]  rd_grid;
    logic [TW-1:0]       last_tbl;
    logic [EW:0]         mid_sum;
    logic [EW-1:0]       mid;
    logic                lerp_start;
    t_lerp_req           lerp_req;
    logic                lerp_busy;
    logic                lerp_done;
    logic [FIX_W-1:0]    lerp_res;
    logic [FIX_W:0]      round_sum;
    logic                out_load;

    assign in_acc = i_in_valid && !o_in_stall;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TABLES_IN_USE) ? {28'd0, r_tin} : 32'd0;

    // Write decode: out-of-range table or entry indexes are dropped.
    always_comb begin
        wr_ok = ({3'd0, i_table_index} < MAXT);
        st_wr.grid_we = in_acc && wr_ok && (t_cmd'(i_command) == CMD_WR_METAL);
        st_wr.rate_we = in_acc && wr_ok && (t_cmd'(i_command) == CMD_WR_RATE)
                        && (32'(i_entry_index) < 32'(TABLE_ENTRIES));
        st_wr.age_we  = in_acc && wr_ok && (t_cmd'(i_command) == CMD_WR_AGE)
                        && (32'(i_entry_index) < 32'(TABLE_ENTRIES));
        st_waddr = AW'(32'(i_table_index) * TABLE_ENTRIES + 32'(i_entry_index));
    end

    always_comb begin
        if (r_tin == 4'd0) begin
            last_tbl = '0;
        end else if ({2'b00, r_tin} > MAXT) begin
            last_tbl = TW'(MAX_TABLES - 1);
        end else begin
            last_tbl = TW'(r_tin - 4'd1);
        end
        mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
        mid      = mid_sum[EW:1];
        tbl_base = AW'(32'(r_tsel) * TABLE_ENTRIES);
    end

    always_comb begin
        case (r_state)
            S_T_LO:  st_raddr = tbl_base;
            S_T_HI:  st_raddr = tbl_base + AW'(TABLE_ENTRIES - 1);
            S_PROBE: st_raddr = tbl_base + AW'(mid);
            default: st_raddr = tbl_base;
        endcase
        case (r_state)
            S_G0_CHK: st_graddr = last_tbl;
            S_SCAN:   st_graddr = r_i;
            default:  st_graddr = '0;
        endcase
    end

    always_comb begin
        lerp_start = 1'b0;
        lerp_req.a   = {r_alo, {FRAC_BITS{1'b0}}};
        lerp_req.b   = {r_ahi, {FRAC_BITS{1'b0}}};
        lerp_req.num = r_rate - r_rlo;
        lerp_req.den = r_rhi - r_rlo;
        if (r_state == S_T_LERP) begin
            lerp_start = (r_rhi != r_rlo);
        end else if (r_state == S_T_DONE && r_two && r_second) begin
            lerp_start   = 1'b1;
            lerp_req.a   = r_tlo;
            lerp_req.b   = r_age;
            lerp_req.num = NUM_W'(r_metal - r_glo);
            lerp_req.den = NUM_W'(r_ghi - r_glo);
        end
    end

    assign round_sum = {1'b0, r_age} + (FIX_W + 1)'(1 << (FRAC_BITS - 1));
    assign out_load  = (r_state == S_FINISH) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tin <= TABLES_RESET;
        end else if (cfg_wr && paddr[2] == REG_TABLES_IN_USE) begin
            r_tin <= pwdata[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
                if (r_fail) begin
                    r_time <= 32'd0;
                    r_oor  <= 1'b1;
                end else begin
                    r_time <= round_sum[FIX_W:FRAC_BITS] > 33'hFFFF_FFFF ? 32'hFFFF_FFFF
                                                            : round_sum[FIX_W-1:FRAC_BITS];
                    r_oor  <= 1'b0;
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc && t_cmd'(i_command) == CMD_QUERY) begin
                        r_rate   <= i_query_rate;
                        r_metal  <= i_query_metal;
                        r_second <= 1'b0;
                        r_fail   <= 1'b0;
                        r_state  <= S_G0;
                    end
                end
                S_G0: r_state <= S_G0_CHK;
                S_G0_CHK: begin
                    r_glo <= rd_grid;
                    if (r_metal <= rd_grid) begin
                        r_two   <= 1'b0;
                        r_tsel  <= '0;
                        r_state <= S_T_LO;
                    end else begin
                        r_state <= S_GN_CHK;
                    end
                end
                S_GN_CHK: begin
                    if (r_metal >= rd_grid) begin
                        r_two   <= 1'b0;
                        r_tsel  <= last_tbl;
                        r_state <= S_T_LO;
                    end else begin
                        r_i     <= TW'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: r_state <= S_SCAN_CHK;
                S_SCAN_CHK: begin
                    // The grid point just read lies above the metallicity, so the scan ends.
                    if (rd_grid > r_metal) begin
                        r_ghi   <= rd_grid;
                        r_two   <= 1'b1;
                        r_tsel  <= r_i - TW'(1);
                        r_state <= S_T_LO;
                    end else begin
                        r_glo   <= rd_grid;
                        r_i     <= r_i + TW'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_T_LO: r_state <= S_T_HI;
                S_T_HI: begin
                    r_rlo   <= rd_rate;
                    r_alo   <= rd_age;
                    r_lo    <= '0;
                    r_hi    <= EW'(TABLE_ENTRIES - 1);
                    r_state <= S_T_CHK;
                end
                S_T_CHK: begin
                    r_rhi <= rd_rate;
                    r_ahi <= rd_age;
                    if (r_rate < r_rlo || r_rate > rd_rate) begin
                        r_fail  <= 1'b1;
                        r_state <= S_FINISH;
                    end else begin
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if ((r_hi - r_lo) > EW'(1)) begin
                        r_mid   <= mid;
                        r_state <= S_STEP;
                    end else begin
                        r_state <= S_T_LERP;
                    end
                end
                S_STEP: begin
                    if (r_rate > rd_rate) begin
                        r_lo  <= r_mid;
                        r_rlo <= rd_rate;
                        r_alo <= rd_age;
                    end else begin
                        r_hi  <= r_mid;
                        r_rhi <= rd_rate;
                        r_ahi <= rd_age;
                    end
                    r_state <= S_PROBE;
                end
                S_T_LERP: begin
                    // A zero-width interval takes the lower age.
                    if (r_rhi == r_rlo) begin
                        r_age   <= {r_alo, {FRAC_BITS{1'b0}}};
                        r_state <= S_T_DONE;
                    end else begin
                        r_state <= S_T_WAIT;
                    end
                end
                S_T_WAIT: begin
                    if (lerp_done) begin
                        r_age   <= lerp_res;
                        r_state <= S_T_DONE;
                    end
                end
                S_T_DONE: begin
                    if (r_two && !r_second) begin
                        r_tlo    <= r_age;
                        r_second <= 1'b1;
                        r_tsel   <= r_tsel + TW'(1);
                        r_state  <= S_T_LO;
                    end else if (r_two) begin
                        r_state <= S_M_WAIT;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_M_WAIT: begin
                    if (lerp_done) begin
                        r_age   <= lerp_res;
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_time_years   = r_time;
    assign o_out_of_range = r_oor;

    icdf_store #(
        .MAX_TABLES    (MAX_TABLES),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr     (st_wr),
        .i_waddr  (st_waddr),
        .i_gwaddr (TW'(i_table_index)),
        .i_wdata  (i_write_value),
        .i_raddr  (st_raddr),
        .i_graddr (st_graddr),
        .o_rate   (rd_rate),
        .o_age    (rd_age),
        .o_grid   (rd_grid)
    );

    icdf_lerp u_lerp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (lerp_start),
        .i_req    (lerp_req),
        .o_busy   (lerp_busy),
        .o_done   (lerp_done),
        .o_result (lerp_res)
    );

    `ICDF_ASSERT_IMP(a_lerp_free, lerp_start, !lerp_busy)
    `ICDF_ASSERT_NXT(a_query_busy, in_acc && i_command == CMD_QUERY, o_in_stall)
    `ICDF_ASSERT_IMP(a_oor_zero, o_out_valid && o_out_of_range, o_time_years == 32'd0)

endmodule
`default_nettype wire
